/* design/nct_pkg.sv */
`timescale 1ns / 1ps
package nct_pkg;

   localparam int MAP_ENTRIES_DEF  = 64;
   localparam int RULE_ENTRIES_DEF = 8;
   localparam int POOL_PORTS_DEF   = 256;

   localparam int MAP_IDX_W  = 12;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [31:0] EXTERNAL_IP_RESET  = 32'd0;
   localparam logic [15:0] POOL_BASE_RESET    = 16'd1024;
   localparam logic [15:0] IDLE_TIMEOUT_RESET = 16'd60;

   localparam logic [CSR_IDX_W-1:0] CSR_EXTERNAL_IP  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_POOL_BASE    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IDLE_TIMEOUT = 2'd2;

   localparam logic [1:0] CMD_TRANSLATE = 2'd0;
   localparam logic [1:0] CMD_TICK      = 2'd1;
   localparam logic [1:0] CMD_ADD_RULE  = 2'd2;
   localparam logic [1:0] CMD_RESERVED  = 2'd3;

   localparam logic [2:0] VERDICT_TRANSLATED = 3'd0;
   localparam logic [2:0] VERDICT_NO_PORT    = 3'd1;
   localparam logic [2:0] VERDICT_NO_MATCH   = 3'd2;
   localparam logic [2:0] VERDICT_TABLE_FULL = 3'd3;
   localparam logic [2:0] VERDICT_RULE_STORED = 3'd4;
   localparam logic [2:0] VERDICT_RULES_FULL = 3'd5;
   localparam logic [2:0] VERDICT_TICK_DONE  = 3'd6;

   localparam logic [6:0] REMOVED_MAX = 7'h7F;

   typedef struct packed {
      logic [1:0]  command;
      logic        direction;
      logic [31:0] peer_ip;
      logic [15:0] peer_port;
      logic [31:0] local_ip;
      logic [15:0] local_port;
      logic [31:0] rule_inside_ip;
      logic [15:0] rule_inside_port;
      logic        fin_flag;
      logic        ack_flag;
      logic [31:0] ack_number;
      logic [31:0] sequence_end;
   } req_item_type;

   typedef struct packed {
      logic [2:0]  verdict;
      logic [31:0] new_ip;
      logic [15:0] new_port;
      logic [6:0]  removed_count;
   } rsp_item_type;

   typedef enum logic [1:0] {
      OP_LOOK_OUT,
      OP_LOOK_IN,
      OP_CREATE,
      OP_SWEEP
   } cell_op_type;

   typedef struct packed {
      logic                 act;
      cell_op_type          op;
      logic                 dir;
      logic                 match_en;
      logic [31:0]          peer_ip;
      logic [15:0]          peer_port;
      logic [31:0]          ins_ip;
      logic [15:0]          ins_port;
      logic [15:0]          out_port;
      logic                 holds;
      logic                 fin;
      logic                 ackf;
      logic [31:0]          ackn;
      logic [31:0]          seqe;
      logic [31:0]          now;
      logic [15:0]          timeout;
      logic [15:0]          base;
      logic [MAP_IDX_W-1:0] index;
      logic                 found;
      logic [31:0]          res_ip;
      logic [15:0]          res_port;
      logic                 free_found;
      logic [MAP_IDX_W-1:0] free_idx;
      logic [6:0]           count;
      logic                 rel;
      logic [15:0]          rel_slot;
   } cell_token_type;

   typedef struct packed {
      logic [31:0] peer_ip;
      logic [15:0] peer_port;
      logic [31:0] inside_ip;
      logic [15:0] inside_port;
      logic [15:0] outside_port;
      logic        holds;
      logic [3:0]  flags;
      logic [31:0] in_seq;
      logic [31:0] out_seq;
      logic [31:0] in_ack;
      logic [31:0] out_ack;
      logic [31:0] last_seen;
   } map_entry_type;

   typedef struct packed {
      logic        done;
      logic        found;
      logic [15:0] slot;
   } pool_status_type;

endpackage

/* design/nct_ifs.sv */
`timescale 1ns / 1ps
interface nct_req_if;
   import nct_pkg::*;
   logic         valid;
   logic         ready;
   req_item_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface nct_rsp_if;
   import nct_pkg::*;
   logic         valid;
   logic         ready;
   rsp_item_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

/* design/nat_connection_table.sv */
`timescale 1ns / 1ps
// TCP port translation table with inbound forwarding rules and a pool of external ports.
// Requests arrive as beats on req_if: translate a packet, a one-second tick, or add a
// forwarding rule. Every request beat yields exactly one response beat on rsp_if, in order.
// The mapping table is a chain of MAP_ENTRIES cells; a request token walks the chain one
// cell per cycle, for a lookup and for a tick sweep. A translate that creates a mapping
// walks the chain a second time. An outbound miss also waits for the free-port scan,
// which checks eight pool ports per cycle in parallel with the first walk. Adding a rule
// or an unknown command is answered without walking the chain. One request is in flight
// at a time, and the next request beat can be taken in the same cycle as the response
// is presented. Reset clears all mapping, rule and pool state, the seconds counter and
// the registers (pool base 1024, idle timeout 60 seconds); no clearing pass is needed.
// A finished response is held in an output register; the next request beat is accepted
// while it waits, but a further response stalls until the receiver takes the held one.
// Registers on the csr_ port are to be written by the user only while no request is in
// flight; the block itself does not enforce this.
module nat_connection_table #(
   parameter int MAP_ENTRIES  = nct_pkg::MAP_ENTRIES_DEF,
   parameter int RULE_ENTRIES = nct_pkg::RULE_ENTRIES_DEF,
   parameter int POOL_PORTS   = nct_pkg::POOL_PORTS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   nct_req_if.sink                        req_if,
   nct_rsp_if.source                      rsp_if,
   input  logic                           csr_wr_en,
   input  logic [nct_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [nct_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import nct_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHAIN,
      ST_DECIDE,
      ST_CREATE,
      ST_FINISH
   } state_type;

   state_type       state_ff, state_in;
   logic [31:0]     ext_ip_ff, ext_ip_in;
   logic [15:0]     base_ff, base_in;
   logic [15:0]     timeout_ff, timeout_in;
   logic [31:0]     now_ff, now_in;
   req_item_type    req_ff, req_in;
   rsp_item_type    res_ff, res_in;
   rsp_item_type    rsp_data_ff, rsp_data_in;
   logic            rsp_valid_ff, rsp_valid_in;
   cell_token_type  launch_ff, launch_in;
   cell_token_type  tail_ff, tail_in;
   logic            rule_hit_ff, rule_hit_in;
   logic [31:0]     rule_ip_ff, rule_ip_in;
   logic [15:0]     rule_port_ff, rule_port_in;

   logic            rule_valid_ff [RULE_ENTRIES];
   logic            rule_valid_in [RULE_ENTRIES];
   logic [31:0]     rule_oip_ff   [RULE_ENTRIES];
   logic [31:0]     rule_oip_in   [RULE_ENTRIES];
   logic [15:0]     rule_oport_ff [RULE_ENTRIES];
   logic [15:0]     rule_oport_in [RULE_ENTRIES];
   logic [31:0]     rule_tip_ff   [RULE_ENTRIES];
   logic [31:0]     rule_tip_in   [RULE_ENTRIES];
   logic [15:0]     rule_tport_ff [RULE_ENTRIES];
   logic [15:0]     rule_tport_in [RULE_ENTRIES];

   cell_token_type  chain_tok [MAP_ENTRIES+1];
   logic            scan_start, set_en, rel_en;
   logic [15:0]     set_slot, rel_slot;
   pool_status_type pool_st;
   logic            accept;

   assign accept        = req_if.valid && req_if.ready;
   assign req_if.ready  = (state_ff == ST_IDLE);
   assign rsp_if.valid  = rsp_valid_ff;
   assign rsp_if.data   = rsp_data_ff;
   assign chain_tok[0]  = launch_ff;

   for (genvar i = 0; i < MAP_ENTRIES; i++) begin : g_cell
      nct_cell #(
         .IDX        (i),
         .POOL_PORTS (POOL_PORTS)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_tok   (chain_tok[i]),
         .down_tok (chain_tok[i+1])
      );
   end

   always_comb begin
      rel_en   = 1'b0;
      rel_slot = '0;
      for (int i = 1; i <= MAP_ENTRIES; i++) begin
         if (chain_tok[i].rel) begin
            rel_en   = 1'b1;
            rel_slot = chain_tok[i].rel_slot;
         end
      end
   end

   nct_pool #(
      .POOL_PORTS (POOL_PORTS)
   ) u_pool (
      .clock    (clock),
      .reset    (reset),
      .start    (scan_start),
      .set_en   (set_en),
      .set_slot (set_slot),
      .clr_en   (rel_en),
      .clr_slot (rel_slot),
      .status   (pool_st)
   );

   always_comb begin
      cell_token_type tk;
      logic           placed;
      logic           rhit;
      req_item_type   r;

      state_in     = state_ff;
      ext_ip_in    = ext_ip_ff;
      base_in      = base_ff;
      timeout_in   = timeout_ff;
      now_in       = now_ff;
      req_in       = req_ff;
      res_in       = res_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      launch_in    = launch_ff;
      launch_in.act = 1'b0;
      tail_in      = tail_ff;
      rule_hit_in  = rule_hit_ff;
      rule_ip_in   = rule_ip_ff;
      rule_port_in = rule_port_ff;
      rule_valid_in = rule_valid_ff;
      rule_oip_in   = rule_oip_ff;
      rule_oport_in = rule_oport_ff;
      rule_tip_in   = rule_tip_ff;
      rule_tport_in = rule_tport_ff;
      scan_start   = 1'b0;
      set_en       = 1'b0;
      set_slot     = '0;
      placed       = 1'b0;
      rhit         = 1'b0;

      r = (state_ff == ST_IDLE) ? req_if.data : req_ff;
      tk             = '0;
      tk.act         = 1'b1;
      tk.dir         = r.direction;
      tk.match_en    = (r.local_ip == ext_ip_ff);
      tk.peer_ip     = r.peer_ip;
      tk.peer_port   = r.peer_port;
      tk.ins_ip      = r.local_ip;
      tk.ins_port    = r.local_port;
      tk.out_port    = r.local_port;
      tk.holds       = !r.direction;
      tk.fin         = r.fin_flag;
      tk.ackf        = r.ack_flag;
      tk.ackn        = r.ack_flag ? r.ack_number : 32'd0;
      tk.seqe        = r.sequence_end;
      tk.now         = now_ff;
      tk.timeout     = timeout_ff;
      tk.base        = base_ff;

      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_EXTERNAL_IP:  ext_ip_in  = csr_wdata;
            CSR_POOL_BASE:    base_in    = csr_wdata[15:0];
            CSR_IDLE_TIMEOUT: timeout_in = csr_wdata[15:0];
            default: begin
            end
         endcase
      end

      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in = req_if.data;
               res_in = '0;
               unique case (req_if.data.command)
                  CMD_TICK: begin
                     now_in    = now_ff + 32'd1;
                     tk.op     = OP_SWEEP;
                     tk.now    = now_ff + 32'd1;
                     launch_in = tk;
                     state_in  = ST_CHAIN;
                  end
                  CMD_ADD_RULE: begin
                     for (int i = 0; i < RULE_ENTRIES; i++) begin
                        if (!placed && !rule_valid_ff[i]) begin
                           placed           = 1'b1;
                           rule_valid_in[i] = 1'b1;
                           rule_oip_in[i]   = req_if.data.local_ip;
                           rule_oport_in[i] = req_if.data.local_port;
                           rule_tip_in[i]   = req_if.data.rule_inside_ip;
                           rule_tport_in[i] = req_if.data.rule_inside_port;
                        end
                     end
                     res_in.verdict = placed ? VERDICT_RULE_STORED : VERDICT_RULES_FULL;
                     state_in       = ST_FINISH;
                  end
                  CMD_TRANSLATE: begin
                     tk.op = req_if.data.direction ? OP_LOOK_IN : OP_LOOK_OUT;
                     launch_in  = tk;
                     scan_start = !req_if.data.direction;
                     for (int i = 0; i < RULE_ENTRIES; i++) begin
                        if (!rhit && rule_valid_ff[i]
                            && (rule_oip_ff[i] == req_if.data.local_ip)
                            && (rule_oport_ff[i] == req_if.data.local_port)) begin
                           rhit         = 1'b1;
                           rule_ip_in   = rule_tip_ff[i];
                           rule_port_in = rule_tport_ff[i];
                        end
                     end
                     rule_hit_in = rhit;
                     state_in    = ST_CHAIN;
                  end
                  default: begin
                     res_in.verdict = VERDICT_NO_MATCH;
                     state_in       = ST_FINISH;
                  end
               endcase
            end
         end
         ST_CHAIN: begin
            if (chain_tok[MAP_ENTRIES].act) begin
               tail_in  = chain_tok[MAP_ENTRIES];
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            tk.op    = OP_CREATE;
            tk.index = tail_ff.free_idx;
            if (tail_ff.op == OP_SWEEP) begin
               res_in.verdict       = VERDICT_TICK_DONE;
               res_in.removed_count = tail_ff.count;
               state_in             = ST_FINISH;
            end else if (tail_ff.found) begin
               res_in.verdict  = VERDICT_TRANSLATED;
               res_in.new_ip   = req_ff.direction ? tail_ff.res_ip : ext_ip_ff;
               res_in.new_port = tail_ff.res_port;
               state_in        = ST_FINISH;
            end else if (!req_ff.direction) begin
               if (pool_st.done) begin
                  if (!tail_ff.free_found) begin
                     res_in.verdict = VERDICT_TABLE_FULL;
                     state_in       = ST_FINISH;
                  end else if (!pool_st.found) begin
                     res_in.verdict = VERDICT_NO_PORT;
                     state_in       = ST_FINISH;
                  end else begin
                     set_en          = 1'b1;
                     set_slot        = pool_st.slot;
                     tk.out_port     = base_ff + pool_st.slot;
                     launch_in       = tk;
                     res_in.verdict  = VERDICT_TRANSLATED;
                     res_in.new_ip   = ext_ip_ff;
                     res_in.new_port = base_ff + pool_st.slot;
                     state_in        = ST_CREATE;
                  end
               end
            end else if (!rule_hit_ff) begin
               res_in.verdict = VERDICT_NO_MATCH;
               state_in       = ST_FINISH;
            end else if (!tail_ff.free_found) begin
               res_in.verdict = VERDICT_TABLE_FULL;
               state_in       = ST_FINISH;
            end else begin
               tk.ins_ip       = rule_ip_ff;
               tk.ins_port     = rule_port_ff;
               launch_in       = tk;
               res_in.verdict  = VERDICT_TRANSLATED;
               res_in.new_ip   = rule_ip_ff;
               res_in.new_port = rule_port_ff;
               state_in        = ST_CREATE;
            end
         end
         ST_CREATE: begin
            if (chain_tok[MAP_ENTRIES].act) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         ext_ip_ff     <= EXTERNAL_IP_RESET;
         base_ff       <= POOL_BASE_RESET;
         timeout_ff    <= IDLE_TIMEOUT_RESET;
         now_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         launch_ff     <= '0;
         for (int i = 0; i < RULE_ENTRIES; i++) begin
            rule_valid_ff[i] <= 1'b0;
         end
      end else begin
         state_ff      <= state_in;
         ext_ip_ff     <= ext_ip_in;
         base_ff       <= base_in;
         timeout_ff    <= timeout_in;
         now_ff        <= now_in;
         rsp_valid_ff  <= rsp_valid_in;
         launch_ff     <= launch_in;
         rule_valid_ff <= rule_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      res_ff        <= res_in;
      rsp_data_ff   <= rsp_data_in;
      tail_ff       <= tail_in;
      rule_hit_ff   <= rule_hit_in;
      rule_ip_ff    <= rule_ip_in;
      rule_port_ff  <= rule_port_in;
      rule_oip_ff   <= rule_oip_in;
      rule_oport_ff <= rule_oport_in;
      rule_tip_ff   <= rule_tip_in;
      rule_tport_ff <= rule_tport_in;
   end

endmodule

/* design/nct_cell.sv */
`timescale 1ns / 1ps
module nct_cell #(
   parameter int IDX        = 0,
   parameter int POOL_PORTS = nct_pkg::POOL_PORTS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  nct_pkg::cell_token_type up_tok,
   output nct_pkg::cell_token_type down_tok
);
   import nct_pkg::*;

   logic           valid_ff, valid_in;
   map_entry_type  ent_ff, ent_in;
   cell_token_type pass_ff, pass_in;
   logic           key_hit, flow_done, expire, opn, upd;
   logic [31:0]    age;
   logic [15:0]    slot_k;

   assign age       = up_tok.now - ent_ff.last_seen;
   assign flow_done = (&ent_ff.flags) && (ent_ff.in_ack >= ent_ff.out_seq)
                      && (ent_ff.out_ack >= ent_ff.in_seq);
   assign expire    = valid_ff && (flow_done || (age >= {16'h0, up_tok.timeout}));
   assign slot_k    = ent_ff.outside_port - up_tok.base;
   assign key_hit   = valid_ff && !up_tok.found
                      && (ent_ff.peer_ip == up_tok.peer_ip)
                      && (ent_ff.peer_port == up_tok.peer_port)
                      && ((up_tok.op == OP_LOOK_OUT)
                          ? ((ent_ff.inside_ip == up_tok.ins_ip)
                             && (ent_ff.inside_port == up_tok.ins_port))
                          : (up_tok.match_en && (ent_ff.outside_port == up_tok.out_port)));

   always_comb begin
      pass_in          = up_tok;
      pass_in.rel      = 1'b0;
      pass_in.rel_slot = '0;
      valid_in         = valid_ff;
      ent_in           = ent_ff;
      opn              = 1'b0;
      upd              = 1'b0;
      if (up_tok.act) begin
         unique case (up_tok.op)
            OP_LOOK_OUT, OP_LOOK_IN: begin
               if (key_hit) begin
                  upd              = 1'b1;
                  pass_in.found    = 1'b1;
                  pass_in.res_ip   = ent_ff.inside_ip;
                  pass_in.res_port = (up_tok.op == OP_LOOK_OUT) ? ent_ff.outside_port
                                                                 : ent_ff.inside_port;
               end
               if (!valid_ff && !up_tok.free_found) begin
                  pass_in.free_found = 1'b1;
                  pass_in.free_idx   = MAP_IDX_W'(IDX);
               end
            end
            OP_CREATE: begin
               if (up_tok.index == MAP_IDX_W'(IDX)) begin
                  opn = 1'b1;
                  upd = 1'b1;
               end
            end
            OP_SWEEP: begin
               if (expire) begin
                  valid_in = 1'b0;
                  if (up_tok.count != REMOVED_MAX) begin
                     pass_in.count = up_tok.count + 7'd1;
                  end
                  if (ent_ff.holds && ({1'b0, slot_k} < 17'(POOL_PORTS))) begin
                     pass_in.rel      = 1'b1;
                     pass_in.rel_slot = slot_k;
                  end
               end
            end
            default: begin
            end
         endcase
      end
      if (opn) begin
         valid_in            = 1'b1;
         ent_in.peer_ip      = up_tok.peer_ip;
         ent_in.peer_port    = up_tok.peer_port;
         ent_in.inside_ip    = up_tok.ins_ip;
         ent_in.inside_port  = up_tok.ins_port;
         ent_in.outside_port = up_tok.out_port;
         ent_in.holds        = up_tok.holds;
         ent_in.flags        = 4'h0;
         ent_in.in_seq       = '0;
         ent_in.out_seq      = '0;
         ent_in.in_ack       = '0;
         ent_in.out_ack      = '0;
      end
      if (upd) begin
         if (!up_tok.dir) begin
            ent_in.flags[0] = up_tok.fin;
            ent_in.flags[2] = up_tok.ackf;
            ent_in.in_seq   = up_tok.seqe;
            ent_in.in_ack   = up_tok.ackn;
         end else begin
            ent_in.flags[1] = up_tok.fin;
            ent_in.flags[3] = up_tok.ackf;
            ent_in.out_seq  = up_tok.seqe;
            ent_in.out_ack  = up_tok.ackn;
         end
         ent_in.last_seen = up_tok.now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pass_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         pass_ff  <= pass_in;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
   end

   assign down_tok = pass_ff;

endmodule

/* design/nct_pool.sv */
`timescale 1ns / 1ps
module nct_pool #(
   parameter int POOL_PORTS = nct_pkg::POOL_PORTS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic                     set_en,
   input  logic [15:0]              set_slot,
   input  logic                     clr_en,
   input  logic [15:0]              clr_slot,
   output nct_pkg::pool_status_type status
);
   import nct_pkg::*;

   localparam int NG   = (POOL_PORTS + 7) / 8;
   localparam int GW   = (NG > 1) ? $clog2(NG) : 1;
   localparam int PIW  = GW + 3;
   localparam int PADN = 8 << GW;

   logic [PADN-1:0] used_ff, used_in;
   logic            scanning_ff, scanning_in;
   logic [GW-1:0]   grp_ff, grp_in;
   logic            done_ff, done_in;
   logic            found_ff, found_in;
   logic [15:0]     slot_ff, slot_in;
   logic [7:0]      grp_bits;
   logic            any_free;
   logic [2:0]      first_free;

   assign grp_bits = used_ff[{grp_ff, 3'b000} +: 8];

   always_comb begin
      any_free   = 1'b0;
      first_free = 3'd0;
      for (int b = 0; b < 8; b++) begin
         if (!any_free && !grp_bits[b] && ({grp_ff, 3'(b)} < PIW'(POOL_PORTS - 1) + PIW'(1)
                                            || POOL_PORTS == PADN)) begin
            any_free   = 1'b1;
            first_free = 3'(b);
         end
      end
   end

   always_comb begin
      used_in     = used_ff;
      scanning_in = scanning_ff;
      grp_in      = grp_ff;
      done_in     = done_ff;
      found_in    = found_ff;
      slot_in     = slot_ff;
      if (set_en) begin
         used_in[set_slot[PIW-1:0]] = 1'b1;
      end
      if (clr_en) begin
         used_in[clr_slot[PIW-1:0]] = 1'b0;
      end
      if (start) begin
         scanning_in = 1'b1;
         grp_in      = '0;
         done_in     = 1'b0;
         found_in    = 1'b0;
      end else if (scanning_ff) begin
         if (any_free) begin
            found_in    = 1'b1;
            slot_in     = 16'({grp_ff, first_free});
            done_in     = 1'b1;
            scanning_in = 1'b0;
         end else if (grp_ff == GW'(NG - 1)) begin
            done_in     = 1'b1;
            scanning_in = 1'b0;
         end else begin
            grp_in = grp_ff + GW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff     <= '0;
         scanning_ff <= 1'b0;
         grp_ff      <= '0;
         done_ff     <= 1'b0;
         found_ff    <= 1'b0;
      end else begin
         used_ff     <= used_in;
         scanning_ff <= scanning_in;
         grp_ff      <= grp_in;
         done_ff     <= done_in;
         found_ff    <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   assign status.done  = done_ff;
   assign status.found = found_ff;
   assign status.slot  = slot_ff;

endmodule

/* dv/nat_connection_table_tb.sv */
`timescale 1ns / 1ps
module nat_connection_table_tb;
   import nct_pkg::*;

   localparam int NMAP  = MAP_ENTRIES_DEF;
   localparam int NRULE = RULE_ENTRIES_DEF;
   localparam int NPOOL = POOL_PORTS_DEF;
   localparam longint CYCLE_LIMIT = 3000000;

   class napt_scoreboard;
      bit [31:0] ext_ip;
      bit [15:0] pool_base;
      bit [15:0] idle_limit;
      bit        map_live[NMAP];
      bit [31:0] map_rip[NMAP];
      bit [15:0] map_rport[NMAP];
      bit [31:0] map_iip[NMAP];
      bit [15:0] map_iport[NMAP];
      bit [15:0] map_oport[NMAP];
      bit        map_pooled[NMAP];
      bit [3:0]  map_flags[NMAP];
      bit [31:0] map_iseq[NMAP];
      bit [31:0] map_oseq[NMAP];
      bit [31:0] map_iack[NMAP];
      bit [31:0] map_oack[NMAP];
      bit [31:0] map_seen[NMAP];
      bit        slot_taken[NPOOL];
      bit        rule_live[NRULE];
      bit [31:0] rule_oip[NRULE];
      bit [15:0] rule_oport[NRULE];
      bit [31:0] rule_tip[NRULE];
      bit [15:0] rule_tport[NRULE];
      bit [31:0] seconds;
      rsp_item_type expected_rsps[$];
      int        errors;
      int        checked;
      int        verdict_hits[8];

      function void clear();
         ext_ip = EXTERNAL_IP_RESET;
         pool_base = POOL_BASE_RESET;
         idle_limit = IDLE_TIMEOUT_RESET;
         foreach (map_live[i]) map_live[i] = 0;
         foreach (slot_taken[i]) slot_taken[i] = 0;
         foreach (rule_live[i]) rule_live[i] = 0;
         seconds = 0;
      endfunction

      function int first_free_entry();
         for (int i = 0; i < NMAP; i++) if (!map_live[i]) return i;
         return -1;
      endfunction

      function int live_entries();
         int n;
         n = 0;
         foreach (map_live[i]) n += map_live[i];
         return n;
      endfunction

      function int free_slots();
         int n;
         n = 0;
         foreach (slot_taken[i]) n += !slot_taken[i];
         return n;
      endfunction

      function void open_entry(int s, bit [31:0] rip, bit [15:0] rport);
         map_live[s] = 1;
         map_rip[s] = rip;
         map_rport[s] = rport;
         map_flags[s] = 0;
         map_iseq[s] = 0;
         map_oseq[s] = 0;
         map_iack[s] = 0;
         map_oack[s] = 0;
      endfunction

      function void note_request(req_item_type q);
         rsp_item_type r;
         bit [31:0] ackn;
         bit [15:0] k;
         int s, p, rl;
         r = '0;
         r.verdict = VERDICT_NO_MATCH;
         ackn = q.ack_flag ? q.ack_number : 32'd0;
         s = -1;
         if (q.command == CMD_TICK) begin
            seconds++;
            for (int i = 0; i < NMAP; i++) begin
               if (map_live[i] && ((map_flags[i] == 4'hF && map_iack[i] >= map_oseq[i] &&
                   map_oack[i] >= map_iseq[i]) || (seconds - map_seen[i]) >= idle_limit)) begin
                  map_live[i] = 0;
                  if (map_pooled[i]) begin
                     k = map_oport[i] - pool_base;
                     if (k < NPOOL) slot_taken[k] = 0;
                  end
                  if (r.removed_count < REMOVED_MAX) r.removed_count++;
               end
            end
            r.verdict = VERDICT_TICK_DONE;
         end else if (q.command == CMD_ADD_RULE) begin
            r.verdict = VERDICT_RULES_FULL;
            for (int i = 0; i < NRULE; i++) begin
               if (!rule_live[i]) begin
                  rule_live[i] = 1;
                  rule_oip[i] = q.local_ip;
                  rule_oport[i] = q.local_port;
                  rule_tip[i] = q.rule_inside_ip;
                  rule_tport[i] = q.rule_inside_port;
                  r.verdict = VERDICT_RULE_STORED;
                  break;
               end
            end
         end else if (q.command == CMD_TRANSLATE && !q.direction) begin
            for (int i = 0; i < NMAP && s < 0; i++)
               if (map_live[i] && map_rip[i] == q.peer_ip && map_rport[i] == q.peer_port &&
                   map_iip[i] == q.local_ip && map_iport[i] == q.local_port) s = i;
            if (s < 0) begin
               s = first_free_entry();
               if (s < 0) r.verdict = VERDICT_TABLE_FULL;
               else begin
                  p = -1;
                  for (int i = 0; i < NPOOL; i++) if (!slot_taken[i]) begin p = i; break; end
                  if (p < 0) begin
                     r.verdict = VERDICT_NO_PORT;
                     s = -1;
                  end else begin
                     slot_taken[p] = 1;
                     open_entry(s, q.peer_ip, q.peer_port);
                     map_iip[s] = q.local_ip;
                     map_iport[s] = q.local_port;
                     map_oport[s] = pool_base + 16'(p);
                     map_pooled[s] = 1;
                  end
               end
            end
            if (s >= 0) begin
               map_flags[s] = (map_flags[s] & 4'b1010) | {1'b0, q.ack_flag, 1'b0, q.fin_flag};
               map_iseq[s] = q.sequence_end;
               map_iack[s] = ackn;
               map_seen[s] = seconds;
               r.verdict = VERDICT_TRANSLATED;
               r.new_ip = ext_ip;
               r.new_port = map_oport[s];
            end
         end else if (q.command == CMD_TRANSLATE) begin
            if (q.local_ip == ext_ip)
               for (int i = 0; i < NMAP && s < 0; i++)
                  if (map_live[i] && map_rip[i] == q.peer_ip &&
                      map_rport[i] == q.peer_port && map_oport[i] == q.local_port) s = i;
            if (s < 0) begin
               rl = -1;
               for (int i = 0; i < NRULE; i++)
                  if (rule_live[i] && rule_oip[i] == q.local_ip &&
                      rule_oport[i] == q.local_port) begin
                     rl = i;
                     break;
                  end
               if (rl >= 0) begin
                  s = first_free_entry();
                  if (s < 0) r.verdict = VERDICT_TABLE_FULL;
                  else begin
                     open_entry(s, q.peer_ip, q.peer_port);
                     map_iip[s] = rule_tip[rl];
                     map_iport[s] = rule_tport[rl];
                     map_oport[s] = q.local_port;
                     map_pooled[s] = 0;
                  end
               end
            end
            if (s >= 0) begin
               map_flags[s] = (map_flags[s] & 4'b0101) | {q.ack_flag, 1'b0, q.fin_flag, 1'b0};
               map_oseq[s] = q.sequence_end;
               map_oack[s] = ackn;
               map_seen[s] = seconds;
               r.verdict = VERDICT_TRANSLATED;
               r.new_ip = map_iip[s];
               r.new_port = map_iport[s];
            end
         end
         expected_rsps.push_back(r);
      endfunction

      function void check_response(rsp_item_type a);
         rsp_item_type e;
         if (expected_rsps.size() == 0) begin
            $display("%0t: response beat with nothing expected: %p", $time, a);
            errors++;
            return;
         end
         e = expected_rsps.pop_front();
         checked++;
         verdict_hits[a.verdict]++;
         if (a.verdict !== e.verdict) begin
            $display("%0t: verdict expected %0d actual %0d", $time, e.verdict, a.verdict);
            errors++;
         end
         if (a.new_ip !== e.new_ip) begin
            $display("%0t: new_ip expected %h actual %h", $time, e.new_ip, a.new_ip);
            errors++;
         end
         if (a.new_port !== e.new_port) begin
            $display("%0t: new_port expected %h actual %h", $time, e.new_port, a.new_port);
            errors++;
         end
         if (a.removed_count !== e.removed_count) begin
            $display("%0t: removed_count expected %0d actual %0d", $time, e.removed_count,
                     a.removed_count);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   nct_req_if req_bus();
   nct_rsp_if rsp_bus();

   napt_scoreboard tracker;
   bit     gaps_on;
   int     sent;
   longint cycles = 0;

   nat_connection_table u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_bus),
      .rsp_if    (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles.", cycles);
         $display("nat_connection_table_tb: FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) tracker.check_response(rsp_bus.data);
   end

   initial begin
      int stall;
      stall = 0;
      rsp_bus.ready = 0;
      forever begin
         @(negedge clock);
         if (gaps_on && stall == 0 && $urandom_range(0, 5) == 0) stall = $urandom_range(1, 4);
         rsp_bus.ready <= (stall == 0);
         if (stall > 0) stall--;
      end
   end

   task automatic send_item(req_item_type q);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_bus.valid <= 1;
      req_bus.data <= q;
      do @(posedge clock); while (!(req_bus.valid && req_bus.ready));
      tracker.note_request(q);
      sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_bus.valid <= 0;
      while (tracker.expected_rsps.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [31:0] value);
      csr_wr_en <= 1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_wr_en <= 0;
      if (idx == CSR_EXTERNAL_IP) tracker.ext_ip = value;
      else if (idx == CSR_POOL_BASE) tracker.pool_base = value[15:0];
      else if (idx == CSR_IDLE_TIMEOUT) tracker.idle_limit = value[15:0];
   endtask

   task automatic set_config(logic [31:0] ip, logic [15:0] base, logic [15:0] limit);
      drain();
      csr_write(CSR_EXTERNAL_IP, ip);
      csr_write(CSR_POOL_BASE, {16'd0, base});
      csr_write(CSR_IDLE_TIMEOUT, {16'd0, limit});
   endtask

   function automatic req_item_type packet(bit dir, logic [31:0] rip, logic [15:0] rport,
                                           logic [31:0] lip, logic [15:0] lport);
      req_item_type q;
      q = '0;
      q.command = CMD_TRANSLATE;
      q.direction = dir;
      q.peer_ip = rip;
      q.peer_port = rport;
      q.local_ip = lip;
      q.local_port = lport;
      return q;
   endfunction

   function automatic req_item_type random_item();
      req_item_type q;
      logic [223:0] raw;
      int mode, e, tries;
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      q = raw[$bits(req_item_type)-1:0];
      mode = $urandom_range(0, 99);
      if (mode < 15) return q;
      if (mode < 25) begin
         q.command = CMD_TICK;
         return q;
      end
      if (mode < 28) begin
         q.command = CMD_ADD_RULE;
         return q;
      end
      q.command = CMD_TRANSLATE;
      if ($urandom_range(0, 1)) begin
         q.ack_number = $urandom_range(0, 15);
         q.sequence_end = $urandom_range(0, 15);
      end
      q.peer_ip = 32'hC0A8_0000 | $urandom_range(0, 3);
      q.peer_port = 16'(80 + $urandom_range(0, 2));
      if (mode < 62) begin
         q.direction = 0;
         q.local_ip = 32'h0A00_0000 | $urandom_range(0, 3);
         q.local_port = 16'(5000 + $urandom_range(0, 3));
         return q;
      end
      q.direction = 1;
      if ($urandom_range(0, 3) != 0 && tracker.live_entries() > 0) begin
         e = $urandom_range(0, NMAP - 1);
         for (tries = 0; tries < NMAP && !tracker.map_live[e]; tries++) e = (e + 1) % NMAP;
         q.peer_ip = tracker.map_rip[e];
         q.peer_port = tracker.map_rport[e];
         q.local_ip = tracker.ext_ip;
         q.local_port = tracker.map_oport[e];
      end else begin
         e = $urandom_range(0, NRULE - 1);
         if (tracker.rule_live[e]) begin
            q.local_ip = tracker.rule_oip[e];
            q.local_port = tracker.rule_oport[e];
         end
      end
      return q;
   endfunction

   task automatic random_phase(int count);
      repeat (count) send_item(random_item());
   endtask

   initial begin
      req_item_type q;
      int inside_port;
      logic [15:0] base;
      tracker = new();
      tracker.clear();
      sent = 0;
      gaps_on = 1;
      reset = 1;
      csr_wr_en = 0;
      csr_index = CSR_EXTERNAL_IP;
      csr_wdata = '0;
      req_bus.valid = 0;
      req_bus.data = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Short directed run on reset configuration values.
      send_item(packet(0, 32'd0, 16'd0, 32'd0, 16'd0));
      send_item(packet(0, 32'd0, 16'd0, 32'd0, 16'd0));
      send_item(packet(1, 32'd0, 16'd0, 32'd0, 16'd1024));
      send_item(packet(1, 32'd1, 16'd0, 32'd0, 16'd1024));
      q = '1;
      q.command = CMD_TRANSLATE;
      q.direction = 0;
      send_item(q);
      q.command = CMD_RESERVED;
      send_item(q);
      q = '1;
      q.command = CMD_ADD_RULE;
      send_item(q);
      send_item(q);
      send_item(packet(1, 32'h1234_5678, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF));
      for (int i = 0; i < 7; i++) begin
         q = '0;
         q.command = CMD_ADD_RULE;
         q.local_ip = 32'h0A0A_0000 + i;
         q.local_port = 16'(8000 + i);
         q.rule_inside_ip = 32'h0A00_0000 | i;
         q.rule_inside_port = 16'(5000 + i);
         send_item(q);
      end
      q = packet(0, 32'h0808_0808, 16'd443, 32'h0A00_0001, 16'd4000);
      q.fin_flag = 1;
      q.ack_flag = 1;
      q.ack_number = 32'd100;
      q.sequence_end = 32'd50;
      send_item(q);
      q = packet(1, 32'h0808_0808, 16'd443, 32'd0, tracker.expected_rsps.size() ?
                 tracker.map_oport[tracker.live_entries() - 1] : 16'd0);
      q.fin_flag = 1;
      q.ack_flag = 1;
      q.ack_number = 32'd50;
      q.sequence_end = 32'd100;
      send_item(q);
      q = '0;
      q.command = CMD_TICK;
      send_item(q);

      set_config($urandom, 16'd0, 16'd1);
      random_phase(60);
      set_config(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
      random_phase(70);
      set_config($urandom, 16'($urandom), 16'd5);
      random_phase(70);
      set_config(32'd0, 16'd1024, 16'd3);
      gaps_on = 0;
      random_phase(80);

      // Leak pool slots by moving the pool base under live mappings, until none is left.
      set_config($urandom, 16'd2000, 16'hFFFF);
      base = 16'd2000;
      inside_port = 0;
      for (int round = 0; round < 5; round++) begin
         while (tracker.live_entries() < NMAP &&
                (round < 4 ? tracker.free_slots() > 0 : inside_port % NMAP != 1)) begin
            send_item(packet(0, 32'h0101_0101, 16'd22, 32'h0A00_0099, 16'(inside_port)));
            inside_port++;
         end
         send_item(packet(0, 32'h0101_0102, 16'd22, 32'h0A00_0099, 16'(inside_port)));
         inside_port++;
         base = base + 16'(NPOOL);
         set_config(tracker.ext_ip, base, 16'd1);
         q = '0;
         q.command = CMD_TICK;
         send_item(q);
         send_item(q);
      end

      drain();
      repeat (200) @(negedge clock);
      $display("Sent %0d request beats, checked %0d response beats.", sent, tracker.checked);
      $display("Verdicts seen: translated %0d, no port %0d, no match %0d, table full %0d, %s",
               tracker.verdict_hits[0], tracker.verdict_hits[1], tracker.verdict_hits[2],
               tracker.verdict_hits[3], $sformatf("rule stored %0d, rules full %0d, tick %0d",
               tracker.verdict_hits[4], tracker.verdict_hits[5], tracker.verdict_hits[6]));
      if (tracker.errors == 0 && tracker.expected_rsps.size() == 0) begin
         $display("nat_connection_table_tb: PASS");
      end else begin
         $display("nat_connection_table_tb: FAIL");
      end
      $finish;
   end

endmodule

/* files.f */
design/nct_pkg.sv
design/nct_ifs.sv
design/nct_cell.sv
design/nct_pool.sv
design/nat_connection_table.sv
dv/nat_connection_table_tb.sv
